[rtl/kde_pkg.sv]
`default_nettype none

package kde_pkg;

	localparam int KEY_BITS   = 6;
	localparam int CNT_BITS   = 8;
	localparam int APB_DATA   = 32;
	localparam int APB_ADDR   = 3;

	// register index, taken from paddr[2]
	localparam logic REG_DEBOUNCE_TICKS = 1'b0;
	localparam logic REG_IDLE_PATTERN   = 1'b1;

	localparam logic [CNT_BITS-1:0] DEBOUNCE_TICKS_RST = CNT_BITS'(20);
	localparam logic [KEY_BITS-1:0] IDLE_PATTERN_RST   = KEY_BITS'(6'h3F);

	typedef struct packed {
		logic [KEY_BITS-1:0] detected_key;
		logic [KEY_BITS-1:0] debounced_key;
		logic [CNT_BITS-1:0] debounce_count;
		logic                event_pending;
	} state_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] debounce_ticks;
		logic [KEY_BITS-1:0] idle_pattern;
	} cfg_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key_pins;
		logic                display_busy;
		logic                event_clear;
	} tick_t;

endpackage

`default_nettype wire

[rtl/kde_step.sv]
`default_nettype none

// One tick of the debounce state: pure next-state logic.
module kde_step (
	input  wire kde_pkg::state_t cur,
	input  wire kde_pkg::cfg_t   cfg,
	input  wire kde_pkg::tick_t  tick,
	output kde_pkg::state_t      nxt
);

	logic                         ep;
	logic [kde_pkg::KEY_BITS-1:0] det1;
	logic [kde_pkg::CNT_BITS-1:0] cnt1;
	logic                         new_key;

	always_comb begin
		ep      = tick.event_clear ? 1'b0 : cur.event_pending;
		nxt     = cur;
		nxt.event_pending = ep;
		new_key = (tick.key_pins != cur.detected_key) && (tick.key_pins != cfg.idle_pattern);
		det1    = new_key ? tick.key_pins : cur.detected_key;
		cnt1    = new_key ? cfg.debounce_ticks : cur.debounce_count;
		if (!tick.display_busy && !ep) begin
			nxt.detected_key   = det1;
			nxt.debounce_count = cnt1;
			if (cnt1 != '0) begin
				nxt.debounce_count = cnt1 - kde_pkg::CNT_BITS'(1);
				if (cnt1 == kde_pkg::CNT_BITS'(1)) begin
					if (det1 == tick.key_pins) begin
						nxt.debounced_key = det1;
					end else begin
						nxt.detected_key = cfg.idle_pattern;
					end
				end
			end
			// release: debounce done and detected matches valid key
			if ((tick.key_pins == cfg.idle_pattern) && (nxt.debounce_count == '0) &&
			    (nxt.detected_key == nxt.debounced_key)) begin
				nxt.detected_key  = cfg.idle_pattern;
				nxt.event_pending = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/keypad_debounce_event_top.sv]
`default_nettype none

// Channel   Direction  Handshake            Word
// tick in   in         in_valid / in_stall  key_pins, display_busy, event_clear
// result    out        out_valid/ out_stall current_key, key_event
// config    APB        psel/penable/pready  debounce_ticks @0x0, idle_pattern @0x4
//
// One word per cycle sustained while out_stall is low. A word is captured in the
// input register; one pass of next-state logic then updates the key state and
// loads the result register, raising out_valid, once that register is free.
// Reset clears the key state, valid flags and config to defaults.
// A stalled result holds; the input register then fills and in_stall rises.
module keypad_debounce_event_top (
	input  wire                           clk,
	input  wire                           arst_n,
	// tick channel
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [kde_pkg::KEY_BITS-1:0]  key_pins,
	input  wire                           display_busy,
	input  wire                           event_clear,
	// result channel
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [kde_pkg::KEY_BITS-1:0]  current_key,
	output logic                          key_event,
	// APB config port
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [kde_pkg::APB_ADDR-1:0]  paddr,
	input  wire  [kde_pkg::APB_DATA-1:0]  pwdata,
	output logic [kde_pkg::APB_DATA-1:0]  prdata,
	output logic                          pready
);

	kde_pkg::cfg_t   cfg_q;
	kde_pkg::state_t state_q;
	kde_pkg::state_t state_nxt;
	kde_pkg::tick_t  tick_s1;
	logic            valid_s1;
	logic            out_free;
	logic            advance;
	logic            take_in;

	// --- config registers ---
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= kde_pkg::DEBOUNCE_TICKS_RST;
			cfg_q.idle_pattern   <= kde_pkg::IDLE_PATTERN_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				kde_pkg::REG_DEBOUNCE_TICKS:
					cfg_q.debounce_ticks <= pwdata[kde_pkg::CNT_BITS-1:0];
				kde_pkg::REG_IDLE_PATTERN:
					cfg_q.idle_pattern <= pwdata[kde_pkg::KEY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			kde_pkg::REG_DEBOUNCE_TICKS:
				prdata = kde_pkg::APB_DATA'(cfg_q.debounce_ticks);
			kde_pkg::REG_IDLE_PATTERN:
				prdata = kde_pkg::APB_DATA'(cfg_q.idle_pattern);
			default: prdata = '0;
		endcase
	end

	// --- handshake ---
	// result register is free when empty or being taken this cycle
	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	// --- input register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			tick_s1.key_pins     <= key_pins;
			tick_s1.display_busy <= display_busy;
			tick_s1.event_clear  <= event_clear;
		end
	end

	// --- next-state logic ---
	kde_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.tick (tick_s1),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// --- result register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			current_key <= state_nxt.debounced_key;
			key_event   <= state_nxt.event_pending;
		end
	end

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT       = 9;     // chance per cycle that a side idles
	localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake
	localparam int MAX_REPORTS    = 200;   // keeps a broken build from flooding the log

	// byte addresses of the two registers on the APB port
	localparam logic [kde_pkg::APB_ADDR-1:0] ADDR_DEBOUNCE_TICKS =
		{kde_pkg::REG_DEBOUNCE_TICKS, 2'b00};
	localparam logic [kde_pkg::APB_ADDR-1:0] ADDR_IDLE_PATTERN   =
		{kde_pkg::REG_IDLE_PATTERN, 2'b00};

	// one result word: the debounced key and the pending-event flag
	typedef struct packed {
		logic [kde_pkg::KEY_BITS-1:0] current_key;
		logic                         key_event;
	} key_report_t;

	logic                         clk;
	logic                         arst_n       = 1'b0;
	logic                         in_valid     = 1'b0;
	logic                         in_stall;
	logic [kde_pkg::KEY_BITS-1:0] key_pins     = '0;
	logic                         display_busy = 1'b0;
	logic                         event_clear  = 1'b0;
	logic                         out_valid;
	logic                         out_stall    = 1'b0;
	logic [kde_pkg::KEY_BITS-1:0] current_key;
	logic                         key_event;
	logic                         psel         = 1'b0;
	logic                         penable      = 1'b0;
	logic                         pwrite       = 1'b0;
	logic [kde_pkg::APB_ADDR-1:0] paddr        = '0;
	logic [kde_pkg::APB_DATA-1:0] pwdata       = '0;
	logic [kde_pkg::APB_DATA-1:0] prdata;
	logic                         pready;

	keypad_debounce_event_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_pins     (key_pins),
		.display_busy (display_busy),
		.event_clear  (event_clear),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.current_key  (current_key),
		.key_event    (key_event),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Scanner shadow: our own copy of the key state and the register values.
	kde_pkg::state_t scan_st;
	kde_pkg::cfg_t   scan_cfg;

	kde_pkg::tick_t  tick_q[$];     // tick words waiting to be driven
	key_report_t     report_q[$];   // result words still owed by the block

	int          errors      = 0;
	int          queued      = 0;
	int          quiet_count = 0;
	logic        tick_taken  = 1'b0;  // driven word was taken at the last rising edge
	logic        steady      = 1'b0;  // no idling on either side while set

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// One tick through the debouncer. Returns the word the block
	// should present afterwards.
	function automatic key_report_t scan_tick(input kde_pkg::tick_t t);
		key_report_t r;
		// a clear acts first, busy or not
		if (t.event_clear)
			scan_st.event_pending = 1'b0;
		// scanning is suspended while the display is busy or an event waits
		if (!t.display_busy && !scan_st.event_pending) begin
			if (t.key_pins != scan_st.detected_key && t.key_pins != scan_cfg.idle_pattern) begin
				scan_st.detected_key   = t.key_pins;
				scan_st.debounce_count = scan_cfg.debounce_ticks;
			end
			// with a zero reload there is no countdown, so nothing goes valid here
			if (scan_st.debounce_count != '0) begin
				scan_st.debounce_count = scan_st.debounce_count - kde_pkg::CNT_BITS'(1);
				if (scan_st.debounce_count == '0) begin
					if (scan_st.detected_key == t.key_pins)
						scan_st.debounced_key = scan_st.detected_key;
					else
						scan_st.detected_key = scan_cfg.idle_pattern;
				end
			end
			// release after a settled key: raise the event
			if (t.key_pins == scan_cfg.idle_pattern && scan_st.debounce_count == '0 &&
			    scan_st.detected_key == scan_st.debounced_key) begin
				scan_st.detected_key  = scan_cfg.idle_pattern;
				scan_st.event_pending = 1'b1;
			end
		end
		r.current_key = scan_st.debounced_key;
		r.key_event   = scan_st.event_pending;
		return r;
	endfunction

	task automatic note_bad(input string what, input int want, input int got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
	endtask

	// Monitor: everything sampled on the rising edge. The result side is
	// checked before the new tick is predicted, so the oldest word stays first.
	always @(posedge clk) begin : monitor
		key_report_t    want;
		kde_pkg::tick_t t;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (report_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t ns: result word with none owed, current_key %0d key_event %0d",
						         $time, current_key, key_event);
				end else begin
					want = report_q.pop_front();
					if (current_key !== want.current_key)
						note_bad("current_key", int'(want.current_key), int'(current_key));
					if (key_event !== want.key_event)
						note_bad("key_event", int'(want.key_event), int'(key_event));
				end
			end
			if (in_valid && !in_stall) begin
				t = {key_pins, display_busy, event_clear};
				report_q.push_back(scan_tick(t));
			end

			// watchdog: any handshake on any port counts as progress
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (psel && penable && pready))
				quiet_count = 0;
			else
				quiet_count++;
			if (quiet_count >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
		tick_taken <= arst_n && in_valid && !in_stall;
	end

	// Driver: moves on at the falling edge once the current word has gone,
	// with random gaps between words and random stalls on the result side.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || tick_taken) begin
				if (tick_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					{key_pins, display_busy, event_clear} <= tick_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic add_tick(input logic [kde_pkg::KEY_BITS-1:0] pins, input logic busy,
	                        input logic clr);
		tick_q.push_back({pins, busy, clr});
		queued++;
	endtask

	// Mostly whole press/hold/release/clear sequences with random keys,
	// bounce and busy ticks; the rest is plain noise.
	task automatic add_random(input int n);
		int                           stop;
		int                           hold;
		int                           deb;
		logic [kde_pkg::KEY_BITS-1:0] idl;
		logic [kde_pkg::KEY_BITS-1:0] key;
		stop = queued + n;
		deb  = int'(scan_cfg.debounce_ticks);
		idl  = scan_cfg.idle_pattern;
		while (queued < stop) begin
			if ($urandom_range(99) < 75) begin
				do
					key = kde_pkg::KEY_BITS'($urandom_range(63));
				while (key == idl);
				// contact bounce before the key settles
				repeat ($urandom_range(0, 2))
					add_tick(kde_pkg::KEY_BITS'($urandom_range(63)), 1'b0, 1'b0);
				if (deb == 0)
					hold = int'($urandom_range(1, 4));
				else if ($urandom_range(99) < 15)
					hold = int'($urandom_range(1, deb));   // let go too early
				else
					hold = deb + int'($urandom_range(0, 2));
				repeat (hold)
					add_tick(key, $urandom_range(99) < 8, 1'b0);
				repeat ($urandom_range(1, 3))
					add_tick(idl, 1'b0, 1'b0);
				// consumer picks up the event
				add_tick($urandom_range(1) ? idl : key, 1'($urandom_range(1)), 1'b1);
			end else begin
				repeat ($urandom_range(1, 6))
					add_tick(kde_pkg::KEY_BITS'($urandom_range(63)), 1'($urandom_range(1)),
					         1'($urandom_range(1)));
			end
		end
	endtask

	// Wait for the block to go quiet: nothing left to drive, nothing owed,
	// then spare edges to let the input and result registers empty.
	task automatic drain();
		while (tick_q.size() != 0 || in_valid || report_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// APB write (setup then access), followed by a read-back of the same register.
	task automatic apb_write(input logic [kde_pkg::APB_ADDR-1:0] addr,
	                         input logic [kde_pkg::APB_DATA-1:0] data);
		logic [kde_pkg::APB_DATA-1:0] mask;
		mask = (addr == ADDR_DEBOUNCE_TICKS) ?
		       kde_pkg::APB_DATA'((1 << kde_pkg::CNT_BITS) - 1) :
		       kde_pkg::APB_DATA'((1 << kde_pkg::KEY_BITS) - 1);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == ADDR_DEBOUNCE_TICKS)
			scan_cfg.debounce_ticks = data[kde_pkg::CNT_BITS-1:0];
		else
			scan_cfg.idle_pattern = data[kde_pkg::KEY_BITS-1:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if ((prdata & mask) !== (data & mask))
			note_bad($sformatf("read-back at 0x%0h", addr), int'(data & mask),
			         int'(prdata & mask));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_cfg(input int ticks, input int idle);
		drain();
		apb_write(ADDR_DEBOUNCE_TICKS, kde_pkg::APB_DATA'(ticks));
		apb_write(ADDR_IDLE_PATTERN, kde_pkg::APB_DATA'(idle));
	endtask

	initial begin : stimulus
		scan_st  = '0;
		scan_cfg = '{debounce_ticks: kde_pkg::DEBOUNCE_TICKS_RST,
		             idle_pattern: kde_pkg::IDLE_PATTERN_RST};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Defaults. Detected and valid keys both come out of reset as zero,
		// so the very first idle tick raises an event.
		add_tick(kde_pkg::IDLE_PATTERN_RST, 1'b0, 1'b0);
		add_tick(6'd0, 1'b1, 1'b1);          // clear still works with the display busy
		add_tick(6'd45, 1'b0, 1'b0);
		add_tick(6'd63, 1'b0, 1'b0);
		add_tick(6'd63, 1'b0, 1'b0);

		// Shortest debounce, all-zero idle pattern.
		set_cfg(1, 0);
		add_tick(6'd63, 1'b0, 1'b0);
		add_tick(6'd0, 1'b0, 1'b0);
		add_tick(6'd21, 1'b0, 1'b0);         // ignored, event pending
		add_tick(6'd21, 1'b0, 1'b1);
		add_tick(6'd42, 1'b1, 1'b0);
		add_tick(6'd0, 1'b0, 1'b0);
		add_tick(6'd0, 1'b0, 1'b1);

		// Longest debounce.
		set_cfg(255, 63);
		add_tick(6'd1, 1'b0, 1'b1);
		add_tick(6'd62, 1'b0, 1'b0);
		add_tick(6'd63, 1'b1, 1'b1);

		// Zero reload: a new key never goes valid through the countdown.
		set_cfg(0, 42);
		add_tick(6'd5, 1'b0, 1'b1);
		add_tick(6'd42, 1'b0, 1'b0);
		add_tick(6'd5, 1'b0, 1'b0);
		add_tick(6'd63, 1'b0, 1'b0);
		add_tick(6'd42, 1'b0, 1'b1);

		// Random phases; the first runs without any idling.
		set_cfg(5, 63);
		steady = 1'b1;
		add_random(350);
		set_cfg(255, 17);
		steady = 1'b0;
		add_random(150);
		set_cfg(1, 0);
		add_random(300);
		set_cfg(3, 63);
		add_random(250);
		set_cfg(0, 33);
		add_random(100);
		set_cfg(int'($urandom_range(2, 30)), int'($urandom_range(63)));
		add_random(300);
		drain();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
